// File: hw/rtl/pcms_pkg.sv
// Package: shared constants, types and command/status structs for the pyramid sketch.
package pcms_pkg;

   localparam int unsigned DefWords         = 16384;
   localparam int unsigned DefLayers        = 15;
   localparam int unsigned DefWordIndexBits = 18;
   localparam int unsigned OffsetBits       = 4;
   localparam int unsigned KeyWidth         = 64;
   localparam int unsigned EstWidth         = 36;
   localparam int unsigned HashCntWidth     = 4;
   localparam logic [HashCntWidth-1:0] HashCntReset = 4'd4;
   localparam int unsigned MinWidth         = 40;
   localparam logic [MinWidth-1:0] MinStart = 40'd1 << 30;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_QUERY  = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SLICE,
      ST_BOT_RD,
      ST_BOT_WAIT,
      ST_BOT_WR,
      ST_UP_RD,
      ST_UP_WAIT,
      ST_UP_ACT,
      ST_PAR_RD,
      ST_PAR_WAIT,
      ST_PAR_ACT,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic load;
      logic slice_next;
      logic bot_rd;
      logic bot_wr;
      logic up_rd;
      logic up_act;
      logic par_rd;
      logic par_act;
      logic layer_next;
      logic fold_min;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic is_query;
      logic is_none;
      logic slices_done;
      logic skip_slice;
      logic nib_full;
      logic nib_empty;
      logic layer_last;
      logic up_stop;
      logic q_stop;
      logic cnt_one;
   } status_type;

endpackage

// File: hw/rtl/pcms_stream_if.sv
// Interface: valid/ready channel used for request and response items.
interface pcms_stream_if #(
   parameter int unsigned Width = 8
);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/pcms_ctrl.sv
// Controller: state machine that sequences slices, layer walks and the clearing pass.
module pcms_ctrl
   import pcms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (stat.clear_done) state_in = ST_IDLE;
         ST_IDLE:     if (req_valid && (!rsp_valid_ff || rsp_ready)) state_in = ST_SLICE;
         ST_SLICE: begin
            if (stat.is_none || stat.slices_done) state_in = ST_DONE;
            else if (stat.skip_slice) state_in = ST_SLICE;
            else state_in = ST_BOT_RD;
         end
         ST_BOT_RD:   state_in = ST_BOT_WAIT;
         ST_BOT_WAIT: begin
            if (stat.is_query) state_in = ST_UP_RD;
            else state_in = ST_BOT_WR;
         end
         ST_BOT_WR: begin
            if ((stat.nib_full && !stat.is_query) || stat.nib_empty) state_in = ST_UP_RD;
            else state_in = ST_SLICE;
         end
         ST_UP_RD:    state_in = ST_UP_WAIT;
         ST_UP_WAIT: begin
            if (stat.is_query) state_in = ST_UP_ACT;
            else if (stat.cnt_one && !stat.layer_last) state_in = ST_PAR_RD;
            else state_in = ST_UP_ACT;
         end
         ST_UP_ACT: begin
            if (stat.is_query) begin
               if (stat.q_stop || stat.layer_last) state_in = ST_SLICE;
               else state_in = ST_UP_RD;
            end else if (stat.up_stop || stat.layer_last) begin
               state_in = ST_SLICE;
            end else begin
               state_in = ST_UP_RD;
            end
         end
         ST_PAR_RD:   state_in = ST_PAR_WAIT;
         ST_PAR_WAIT: state_in = ST_PAR_ACT;
         ST_PAR_ACT:  state_in = ST_SLICE;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear_step = 1'b1;
         ST_IDLE:   cmd.load = req_valid && (!rsp_valid_ff || rsp_ready);
         ST_SLICE:  cmd.slice_next = !(stat.is_none || stat.slices_done) && stat.skip_slice;
         ST_BOT_RD: cmd.bot_rd = 1'b1;
         ST_BOT_WAIT: cmd.fold_min = 1'b0;
         ST_BOT_WR: begin
            cmd.bot_wr = 1'b1;
            cmd.slice_next = !((stat.nib_full && !stat.is_query) || stat.nib_empty);
         end
         ST_UP_RD:  cmd.up_rd = 1'b1;
         ST_UP_WAIT: cmd.bot_wr = 1'b0;
         ST_UP_ACT: begin
            cmd.up_act = 1'b1;
            if (stat.is_query) begin
               cmd.slice_next = stat.q_stop || stat.layer_last;
               cmd.fold_min   = stat.q_stop || stat.layer_last;
               cmd.layer_next = !(stat.q_stop || stat.layer_last);
            end else begin
               cmd.slice_next = stat.up_stop || stat.layer_last;
               cmd.layer_next = !(stat.up_stop || stat.layer_last);
            end
         end
         ST_PAR_RD:   cmd.par_rd = 1'b1;
         ST_PAR_WAIT: cmd.par_rd = 1'b0;
         ST_PAR_ACT: begin
            cmd.par_act    = 1'b1;
            cmd.slice_next = 1'b1;
         end
         ST_DONE:   cmd.out_load = 1'b1;
         default:   cmd = '0;
      endcase
   end

   // Hold the result until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (state_ff == ST_DONE) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/pcms_dp.sv
// Datapath: bottom and upper layer memories, slice walk, carry/borrow and query accumulation.
module pcms_dp
   import pcms_pkg::*;
#(
   parameter int unsigned Words         = DefWords,
   parameter int unsigned Layers        = DefLayers,
   parameter int unsigned WordIndexBits = DefWordIndexBits
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              stat,
   input  logic [1:0]              req_func,
   input  logic [KeyWidth-1:0]     req_key_hash,
   input  logic [HashCntWidth-1:0] num_hashes,
   output logic [EstWidth-1:0]     rsp_estimate
);

   localparam int unsigned WBits  = $clog2(Words);
   localparam int unsigned LBits  = $clog2(Layers);
   localparam int unsigned UpDepth = Words + Layers;
   localparam int unsigned UBits  = $clog2(UpDepth);
   localparam int unsigned CBits  = (WBits > UBits) ? WBits : UBits;
   localparam int unsigned RestW  = KeyWidth - WordIndexBits;

   // Upper-layer base address of layer l: the sum of the sizes of the upper layers below it.
   function automatic logic [UBits-1:0] base_of(input logic [LBits-1:0] l);
      int unsigned b;
      b = 0;
      for (int j = 1; j < Layers; j++) begin
         if (j < l) b = b + (((Words - 1) >> j) + 1);
      end
      return UBits'(b);
   endfunction

   logic [63:0] bot_mem [Words];
   logic [63:0] up_mem [UpDepth];
   logic [63:0] bot_rd_ff, up_rd_ff;

   logic [CBits:0]           clr_ff, clr_in;
   func_type                 func_ff;
   logic [RestW-1:0]         rest_ff, rest_in;
   logic [WBits-1:0]         w_ff;
   logic [HashCntWidth-1:0]  hcnt_ff, hcnt_in;
   logic [15:0]              touched_ff, touched_in;
   logic [LBits-1:0]         layer_ff, layer_in;
   logic signed [MinWidth-1:0] high_ff, high_in, minv_ff, minv_in;
   logic [EstWidth-1:0]      est_ff;
   logic [63:0]              up_hold_ff;
   logic [UBits-1:0]         up_addr_ff;
   logic [WordIndexBits-1:0] wlow;
   logic [31:0]              wrem;
   logic [WBits-1:0]         w_mod;
   logic [3:0]               off;
   logic [5:0]               sh;
   logic [3:0]               bnib, unib, pnib;
   logic                     side, pside;
   logic [WBits-1:0]         idx;
   logic [UBits-1:0]         up_addr, par_addr;
   logic [63:0]              bot_new, up_new, par_fix;
   logic [1:0]               ucnt;
   logic signed [MinWidth-1:0] digit, qval, fold_v;
   logic [5:0]               qamt;

   assign off  = rest_ff[3:0];
   assign sh   = {off, 2'b00};
   assign bnib = 4'(bot_rd_ff >> sh);
   assign unib = 4'(up_rd_ff >> sh);
   assign ucnt = unib[1:0];
   assign side = w_ff[layer_ff - 1'b1];
   assign idx  = w_ff >> layer_ff;
   assign pside = idx[1];
   assign up_addr  = base_of(layer_ff) + UBits'(idx);
   assign par_addr = base_of(layer_ff + 1'b1) + UBits'(idx >> 1);
   assign pnib = 4'(up_rd_ff >> sh);

   // Reduce the low hash bits modulo the word count: they stay below 16 times it,
   // so subtract 8, 4, 2 and 1 times the count where it fits.
   assign wlow = req_key_hash[WordIndexBits-1:0];
   always_comb begin
      wrem = 32'(wlow);
      for (int k = 3; k >= 0; k--) begin
         if (wrem >= (32'(Words) << k)) wrem = wrem - (32'(Words) << k);
      end
      w_mod = wrem[WBits-1:0];
   end

   // Query digit of this layer and the value folded into the minimum.
   always_comb begin
      digit  = MinWidth'(signed'({1'b0, ucnt})) - MinWidth'(signed'({1'b0, unib[2 + {1'b0, ~side}]}));
      qamt   = 6'd2 + {layer_ff, 1'b0};
      qval   = digit <<< qamt;
      fold_v = high_ff + signed'(MinWidth'(bnib));
      if (unib[2 + {1'b0, side}]) fold_v = fold_v + qval;
   end

   // Next values of bottom and upper words.
   always_comb begin
      bot_new = bot_rd_ff;
      if (func_ff == FUNC_INSERT) begin
         if (bnib == 4'hF) bot_new = bot_rd_ff & ~(64'hF << sh);
         else bot_new = bot_rd_ff + (64'd1 << sh);
      end else begin
         if (bnib == 4'h0) bot_new = bot_rd_ff | (64'hF << sh);
         else bot_new = bot_rd_ff - (64'd1 << sh);
      end
      up_new = up_rd_ff;
      if (func_ff == FUNC_INSERT) begin
         up_new = up_rd_ff | (64'd1 << (sh + 6'd2 + {5'd0, side}));
         if (ucnt == 2'd3) up_new = up_new & ~(64'h3 << sh);
         else up_new = up_new + (64'd1 << sh);
      end else begin
         if (ucnt >= 2'd2) up_new = up_rd_ff - (64'd1 << sh);
         else if (ucnt == 2'd1) up_new = (up_rd_ff & ~(64'd1 << (sh + 6'd2 + {5'd0, side})))
                                          - (64'd1 << sh);
         else up_new = up_rd_ff | (64'h3 << sh);
      end
      par_fix = up_hold_ff;
      if (!pnib[2 + {1'b0, pside}])
         par_fix = up_hold_ff & ~(64'd1 << (sh + 6'd2 + {5'd0, side}));
      par_fix = par_fix - (64'd1 << sh);
   end

   // Memory ports: one write, one registered read each.
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         if (clr_ff < (CBits+1)'(Words)) bot_mem[clr_ff[WBits-1:0]] <= '0;
      end else if (cmd.bot_wr && func_ff != FUNC_QUERY) begin
         bot_mem[w_ff] <= bot_new;
      end
      if (cmd.bot_rd) bot_rd_ff <= bot_mem[w_ff];
      if (cmd.clear_step) begin
         if (clr_ff < (CBits+1)'(UpDepth)) up_mem[clr_ff[UBits-1:0]] <= '0;
      end else if (cmd.up_act && func_ff != FUNC_QUERY && !(func_ff == FUNC_DELETE
            && ucnt == 2'd1 && layer_ff != LBits'(Layers - 1))) begin
         up_mem[up_addr] <= up_new;
      end else if (cmd.par_act) begin
         up_mem[up_addr_ff] <= par_fix;
      end
      if (cmd.up_rd) up_rd_ff <= up_mem[up_addr];
      else if (cmd.par_rd) up_rd_ff <= up_mem[par_addr];
   end

   // Sequencing registers.
   always_comb begin
      clr_in     = clr_ff;
      rest_in    = rest_ff;
      hcnt_in    = hcnt_ff;
      touched_in = touched_ff;
      layer_in   = layer_ff;
      high_in    = high_ff;
      minv_in    = minv_ff;
      if (cmd.clear_step) clr_in = clr_ff + 1'b1;
      if (cmd.load) begin
         rest_in    = req_key_hash[KeyWidth-1:WordIndexBits];
         hcnt_in    = '0;
         touched_in = '0;
         minv_in    = MinStart;
      end
      if (cmd.bot_rd) begin
         layer_in   = LBits'(1);
         high_in    = '0;
         touched_in = touched_ff | (16'd1 << off);
      end
      if (cmd.up_act && func_ff == FUNC_QUERY && unib[2 + {1'b0, side}])
         high_in = high_ff + qval;
      if (cmd.layer_next) layer_in = layer_ff + 1'b1;
      if (cmd.fold_min && fold_v < minv_ff) minv_in = fold_v;
      if (cmd.slice_next) begin
         rest_in = rest_ff >> OffsetBits;
         hcnt_in = hcnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
      rest_ff    <= rest_in;
      hcnt_ff    <= hcnt_in;
      touched_ff <= touched_in;
      layer_ff   <= layer_in;
      high_ff    <= high_in;
      minv_ff    <= minv_in;
      if (cmd.up_act) up_hold_ff <= up_new;
      if (cmd.par_rd) begin
         up_hold_ff <= up_rd_ff;
         up_addr_ff <= up_addr;
      end
      if (cmd.load) begin
         func_ff <= func_type'(req_func);
         w_ff    <= w_mod;
      end
      if (cmd.out_load) begin
         if (func_ff != FUNC_QUERY) est_ff <= '0;
         else if (minv_ff < 0) est_ff <= '0;
         else if (minv_ff > MinWidth'(64'hF_FFFF_FFFF)) est_ff <= '1;
         else est_ff <= EstWidth'(minv_ff);
      end
   end

   // Status back to the controller.
   always_comb begin
      stat             = '0;
      stat.clear_done  = clr_ff >= (CBits+1)'(UpDepth);
      stat.is_query    = func_ff == FUNC_QUERY;
      stat.is_none     = func_ff == FUNC_NONE;
      stat.slices_done = hcnt_ff >= num_hashes;
      stat.skip_slice  = func_ff != FUNC_QUERY && touched_ff[off];
      stat.nib_full    = func_ff == FUNC_INSERT && bnib == 4'hF;
      stat.nib_empty   = func_ff == FUNC_DELETE && bnib == 4'h0;
      stat.layer_last  = layer_ff == LBits'(Layers - 1);
      stat.up_stop     = (func_ff == FUNC_INSERT) ? (ucnt != 2'd3) : (ucnt != 2'd0);
      stat.q_stop      = !unib[2 + {1'b0, side}];
      stat.cnt_one     = func_ff == FUNC_DELETE && ucnt == 2'd1;
   end

   assign rsp_estimate = est_ff;

endmodule

// File: hw/rtl/pyramid_count_min_sketch.sv
// Top level: pyramid count-min sketch with request, response and register ports.
//
//  channel  dir  payload                        handshake
//  req      in   func[1:0], key_hash[63:0]      req_valid / req_ready
//  rsp      out  estimate[35:0]                 rsp_valid / rsp_ready
//  csr      in   num_hashes[3:0]                csr_wr_en
//
// Each item is loaded, then each slice skips a repeated counter or reads the bottom word,
// waits and, for insert and delete, writes it back; each upper layer walked is read, waited
// on and acted on, as is the parent when a borrow checks it; the memories are read-modify-
// written with registered reads, one layer per step. After reset a clearing pass zeroes both memories;
// req_ready stays low. A result not yet taken holds req_ready low until it is taken.
module pyramid_count_min_sketch
   import pcms_pkg::*;
#(
   parameter int unsigned Words         = DefWords,
   parameter int unsigned Layers        = DefLayers,
   parameter int unsigned WordIndexBits = DefWordIndexBits
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_func,
   input  logic [KeyWidth-1:0]     req_key_hash,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [EstWidth-1:0]     rsp_estimate,
   input  logic                    csr_wr_en,
   input  logic [HashCntWidth-1:0] csr_wr_data
);

   logic [HashCntWidth-1:0] num_hashes_ff;
   cmd_type    cmd;
   status_type stat;

   // Hold the hash count register.
   always_ff @(posedge clock) begin
      if (reset) num_hashes_ff <= HashCntReset;
      else if (csr_wr_en) num_hashes_ff <= csr_wr_data;
   end

   pcms_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   pcms_dp #(.Words(Words), .Layers(Layers), .WordIndexBits(WordIndexBits)) u_dp (
      .clock, .reset, .cmd, .stat, .req_func, .req_key_hash,
      .num_hashes(num_hashes_ff), .rsp_estimate
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_estimate))
      else $error("response dropped while stalled");
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready)
      else $error("item taken while a result is held");

endmodule

// File: test/tb_pyramid_count_min_sketch.sv
// Testbench: self-checking regression of the pyramid count-min sketch top level.
module tb_pyramid_count_min_sketch;
   import pcms_pkg::*;

   localparam int unsigned WORDS     = DefWords;
   localparam int unsigned LAYERS    = DefLayers;
   localparam int unsigned REQ_W     = 2 + KeyWidth;
   localparam int unsigned RAND_ITEMS = 1520;
   localparam int unsigned POOL_SIZE = 6;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [HashCntWidth-1:0] csr_wr_data;

   pcms_stream_if #(.Width(REQ_W)) req_if ();
   pcms_stream_if #(.Width(EstWidth)) rsp_if ();

   pyramid_count_min_sketch uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_if.valid),
      .req_ready    (req_if.ready),
      .req_func     (req_if.data[REQ_W-1 -: 2]),
      .req_key_hash (req_if.data[KeyWidth-1:0]),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_estimate (rsp_if.data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   // Shadow copy of the sketch stores and the hash-count register
   logic [63:0] bottom_mem [WORDS];
   logic [63:0] upper_mem [WORDS + LAYERS];
   logic [HashCntWidth-1:0] hash_cnt;

   logic [EstWidth-1:0] estimate_q [$];
   int unsigned fail_cnt;
   int unsigned checked_cnt;
   int unsigned op_cnt [4];
   int unsigned burst_left;
   logic [63:0] key_pool [POOL_SIZE];

   always #10 clock = ~clock;

   function automatic int unsigned layer_base(int unsigned layer);
      int unsigned base;
      base = 0;
      for (int unsigned j = 1; j < layer; j++) base += ((WORDS - 1) >> j) + 1;
      return base;
   endfunction

   // Carry an overflow up the pyramid
   function automatic void lift_carry(int unsigned w, int unsigned off);
      int unsigned side;
      int unsigned p;
      logic [1:0] cnt;
      for (int unsigned i = 1; i < LAYERS; i++) begin
         side = (w >> (i - 1)) & 1;
         p = layer_base(i) + (w >> i);
         upper_mem[p][off*4 + 2 + side] = 1'b1;
         cnt = upper_mem[p][off*4 +: 2];
         if (cnt != 2'd3) begin
            upper_mem[p][off*4 +: 2] = cnt + 2'd1;
            return;
         end
         upper_mem[p][off*4 +: 2] = 2'd0;
      end
   endfunction

   // Borrow an underflow from the pyramid
   function automatic void pull_borrow(int unsigned w, int unsigned off);
      int unsigned side;
      int unsigned idx;
      int unsigned p;
      int unsigned pside;
      logic [1:0] cnt;
      logic [3:0] upv;
      for (int unsigned i = 1; i < LAYERS; i++) begin
         side = (w >> (i - 1)) & 1;
         idx = w >> i;
         p = layer_base(i) + idx;
         cnt = upper_mem[p][off*4 +: 2];
         if (cnt >= 2'd2) begin
            upper_mem[p][off*4 +: 2] = cnt - 2'd1;
            return;
         end
         if (cnt == 2'd1) begin
            pside = (idx >> 1) & 1;
            upv = 4'd0;
            if (i + 1 < LAYERS) upv = upper_mem[layer_base(i + 1) + (idx >> 1)][off*4 +: 4];
            if (!upv[2 + pside]) upper_mem[p][off*4 + 2 + side] = 1'b0;
            upper_mem[p][off*4 +: 2] = 2'd0;
            return;
         end
         upper_mem[p][off*4 +: 2] = 2'd3;
      end
   endfunction

   // Rebuild the upper part of a counter from the flagged layers
   function automatic longint stack_high(int unsigned w, int unsigned off);
      int unsigned side;
      logic [3:0] v;
      longint high;
      longint digit;
      high = 0;
      for (int unsigned i = 1; i < LAYERS; i++) begin
         side = (w >> (i - 1)) & 1;
         v = upper_mem[layer_base(i) + (w >> i)][off*4 +: 4];
         if (!v[2 + side]) return high;
         digit = longint'(v[1:0]) - longint'(v[2 + (side ^ 1)]);
         high += digit * (longint'(1) << (2 + 2 * i));
      end
      return high;
   endfunction

   // Apply one item to the shadow sketch and return its estimate
   function automatic logic [EstWidth-1:0] sketch_apply(func_type f, logic [63:0] key);
      int unsigned w;
      int unsigned off;
      logic [63:0] h;
      logic [15:0] touched;
      logic [3:0] nib;
      longint minv;
      longint v;
      w = key[17:0] % WORDS;
      h = key >> 18;
      touched = '0;
      minv = longint'(1) << 30;
      if (f == FUNC_NONE) return '0;
      for (int unsigned i = 0; i < hash_cnt; i++) begin
         off = h[3:0];
         h = h >> 4;
         nib = bottom_mem[w][off*4 +: 4];
         if (f == FUNC_QUERY) begin
            v = longint'(nib) + stack_high(w, off);
            if (v < minv) minv = v;
         end else if (!touched[off]) begin
            touched[off] = 1'b1;
            if (f == FUNC_INSERT) begin
               bottom_mem[w][off*4 +: 4] = nib + 4'd1;
               if (nib == 4'hF) lift_carry(w, off);
            end else begin
               bottom_mem[w][off*4 +: 4] = nib - 4'd1;
               if (nib == 4'h0) pull_borrow(w, off);
            end
         end
      end
      if (f != FUNC_QUERY) return '0;
      if (minv < 0) minv = 0;
      if (minv > longint'(36'hF_FFFF_FFFF)) minv = longint'(36'hF_FFFF_FFFF);
      return minv[EstWidth-1:0];
   endfunction

   // Send one item in bursts with random gaps, predict on acceptance
   task automatic send_item(func_type f, logic [63:0] key);
      int unsigned gap;
      req_if.valid <= 1'b1;
      req_if.data <= {f, key};
      do @(posedge clock); while (!req_if.ready);
      estimate_q.push_back(sketch_apply(f, key));
      op_cnt[f]++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain;
      req_if.valid <= 1'b0;
      while (estimate_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Write the hash count once the block is idle
   task automatic set_hash_cnt(logic [HashCntWidth-1:0] val);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      hash_cnt = val;
   endtask

   // Receiver stalls: alternate between always-ready runs and random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if ((checked_cnt / 64) % 3 == 1) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 1) == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      logic [EstWidth-1:0] want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (estimate_q.size() == 0) begin
            $error("estimate: unexpected result, actual %0d", rsp_if.data);
            fail_cnt++;
         end else begin
            want = estimate_q.pop_front();
            checked_cnt++;
            if (rsp_if.data !== want) begin
               $error("estimate: expected %0d, actual %0d", want, rsp_if.data);
               fail_cnt++;
            end
         end
      end
   end

   task automatic test_fields;
      send_item(FUNC_QUERY, 64'h0);
      send_item(FUNC_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(FUNC_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(FUNC_NONE, 64'h1234_5678_9ABC_DEF0);
      // every slice on counter 0: one change per insert
      send_item(FUNC_INSERT, 64'h0);
      send_item(FUNC_QUERY, 64'h0);
      send_item(FUNC_DELETE, 64'h0);
   endtask

   task automatic test_pyramid_walk;
      logic [63:0] k;
      k = 64'h0000_0000_0ABC_1555;
      // empty counter: borrow to the top, then carry back through the top
      send_item(FUNC_DELETE, k);
      send_item(FUNC_QUERY, k);
      send_item(FUNC_INSERT, k);
      send_item(FUNC_QUERY, k);
      repeat (17) send_item(FUNC_INSERT, k);
      send_item(FUNC_QUERY, k);
      send_item(FUNC_DELETE, k);
      send_item(FUNC_QUERY, k);
   endtask

   task automatic test_hash_counts;
      set_hash_cnt(4'd0);
      send_item(FUNC_INSERT, key_pool[0]);
      send_item(FUNC_QUERY, key_pool[0]);
      set_hash_cnt(4'd15);
      send_item(FUNC_INSERT, key_pool[1]);
      send_item(FUNC_QUERY, key_pool[1]);
      set_hash_cnt(4'd1);
      send_item(FUNC_DELETE, key_pool[2]);
      send_item(FUNC_QUERY, key_pool[2]);
      set_hash_cnt(4'd11);
      send_item(FUNC_QUERY, key_pool[2]);
   endtask

   task automatic test_random;
      logic [63:0] k;
      int unsigned r;
      for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
         if (n % 256 == 0) set_hash_cnt(HashCntWidth'($urandom_range(0, 15)));
         // mostly hot keys so counters climb and fall through the layers
         if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else k = {$urandom, $urandom};
         r = $urandom_range(0, 19);
         if (r < 10) send_item(FUNC_INSERT, k);
         else if (r < 14) send_item(FUNC_DELETE, k);
         else if (r < 19) send_item(FUNC_QUERY, k);
         else send_item(FUNC_NONE, k);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      fail_cnt = 0;
      checked_cnt = 0;
      burst_left = 0;
      hash_cnt = HashCntReset;
      for (int unsigned i = 0; i < 4; i++) op_cnt[i] = 0;
      for (int unsigned i = 0; i < WORDS; i++) bottom_mem[i] = '0;
      for (int unsigned i = 0; i < WORDS + LAYERS; i++) upper_mem[i] = '0;
      // pool keys share a few words so counters collide
      for (int unsigned i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = {$urandom, $urandom};
         key_pool[i][17:0] = 18'(i % 3);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_fields();
      test_pyramid_walk();
      test_hash_counts();
      test_random();
      drain();
      $display("checked %0d results: %0d insert, %0d query, %0d delete, %0d unused",
         checked_cnt, op_cnt[FUNC_INSERT], op_cnt[FUNC_QUERY], op_cnt[FUNC_DELETE],
         op_cnt[FUNC_NONE]);
      $display("hash counts 0 to 15 with carries and borrows through the top layer");
      if (fail_cnt == 0) begin
         $display("pyramid_count_min_sketch regression: pass");
      end else begin
         $display("pyramid_count_min_sketch regression: fail");
      end
      $finish;
   end

   initial begin
      #300_000_000;
      $display("pyramid_count_min_sketch regression: fail");
      $finish;
   end

endmodule

// File: pyramid_count_min_sketch.f
hw/rtl/pcms_pkg.sv
hw/rtl/pcms_stream_if.sv
hw/rtl/pcms_ctrl.sv
hw/rtl/pcms_dp.sv
hw/rtl/pyramid_count_min_sketch.sv
test/tb_pyramid_count_min_sketch.sv
